[rtl/itp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itp_pkg: shared definitions of the interlaced track table placer
// Slot geometry, field widths, outcome codes and the structs passed between
// the search unit and the top level.
// ---------------------------------------------------------------------------
package itp_pkg;

  // Slot geometry.
  localparam int SLOT_COUNT       = 320;
  localparam int SECTORS_PER_SLOT = 32;
  localparam int EVEN_CAP         = (SLOT_COUNT + 1) / 2;
  localparam int ODD_CAP          = SLOT_COUNT / 2;

  // Internal widths derived from the geometry.
  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int HCNT_W = $clog2(EVEN_CAP + 1);

  // Fixed field widths.
  localparam int LEVEL_W    = 4;
  localparam int KEY_W      = 32;
  localparam int ENTRY_W    = LEVEL_W + KEY_W;
  localparam int OUTCOME_W  = 3;
  localparam int SLOT_OUT_W = 9;
  localparam int CLS_W      = 2;
  localparam int SECT_W     = 20;
  localparam int TOTAL_W    = 32;

  // Result outcome codes.
  typedef enum logic [OUTCOME_W-1:0] {
    OC_BOT_OVR  = 3'd0,
    OC_TOP_EVEN = 3'd1,
    OC_TOP_ODD  = 3'd2,
    OC_NEW_BOT  = 3'd3,
    OC_NEW_EVEN = 3'd4,
    OC_NEW_ODD  = 3'd5,
    OC_FULL     = 3'd6
  } outcome_e;

  // Fill counts; slots fill in order, so they also tell which slots are valid.
  typedef struct packed {
    logic [CNT_W-1:0]  bottom;
    logic [HCNT_W-1:0] even;
    logic [HCNT_W-1:0] odd;
  } fill_t;

  // First matching slot of each half, as found by the search unit.
  typedef struct packed {
    logic             b_hit;
    logic [IDX_W-1:0] b_idx;
    logic             t_hit;
    logic [IDX_W-1:0] t_idx;
  } scan_res_t;

  // A bottom slot is valid when it lies below the bottom fill count.
  function automatic logic bottom_valid(input logic [IDX_W-1:0] idx, input fill_t fill);
    return CNT_W'(idx) < fill.bottom;
  endfunction

  // Even top slots fill from the even count, odd ones from the odd count.
  function automatic logic top_valid(input logic [IDX_W-1:0] idx, input fill_t fill);
    logic [CNT_W-1:0] half;
    half = CNT_W'(idx[IDX_W-1:1]);
    if (idx[0]) begin
      return half < CNT_W'(fill.odd);
    end
    return half < CNT_W'(fill.even);
  endfunction

endpackage

[rtl/itp_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itp_store: slot entry memory
// One synchronous memory of level and key per slot, one write port and one
// read port with registered read data.
// ---------------------------------------------------------------------------
module itp_store
  import itp_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IDX_W-1:0]   waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [IDX_W-1:0]   raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [SLOT_COUNT];
  logic [ENTRY_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/itp_scan.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itp_scan: slot search unit
// Walks both slot memories in rising order, one slot per cycle, and keeps
// the lowest valid bottom and top slot whose entry matches the item.
// ---------------------------------------------------------------------------
module itp_scan
  import itp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic [KEY_W-1:0]   key_i,
  input  fill_t              fill_i,
  input  logic [ENTRY_W-1:0] bot_rdata_i,
  input  logic [ENTRY_W-1:0] top_rdata_i,
  output logic               rd_en_o,
  output logic [IDX_W-1:0]   rd_addr_o,
  output logic               done_o,
  output scan_res_t          res_o
);

  localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(SLOT_COUNT - 1);

  logic             busy_q;
  logic [CNT_W-1:0] addr_q;
  logic             cmp_q;
  logic             last_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             done_q;
  scan_res_t        res_q;
  logic             bot_match;
  logic             top_match;

  assign rd_en_o   = busy_q;
  assign rd_addr_o = addr_q[IDX_W-1:0];
  assign done_o    = done_q;
  assign res_o     = res_q;

  // Compare the entry read in the previous cycle against the item.
  assign bot_match = cmp_q && bottom_valid(cmp_idx_q, fill_i) &&
                     (bot_rdata_i == {level_i, key_i});
  assign top_match = cmp_q && top_valid(cmp_idx_q, fill_i) &&
                     (top_rdata_i == {level_i, key_i});

  // Address sweep, compare stage and first-hit capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      addr_q    <= '0;
      cmp_q     <= 1'b0;
      last_q    <= 1'b0;
      cmp_idx_q <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      cmp_q     <= busy_q;
      cmp_idx_q <= addr_q[IDX_W-1:0];
      last_q    <= busy_q && (addr_q == LAST_ADDR);
      done_q    <= cmp_q && last_q;
      if (start_i) begin
        busy_q <= 1'b1;
        addr_q <= '0;
        res_q  <= '0;
      end else begin
        if (busy_q) begin
          addr_q <= addr_q + CNT_W'(1);
          if (addr_q == LAST_ADDR) begin
            busy_q <= 1'b0;
          end
        end
        if (bot_match && !res_q.b_hit) begin
          res_q.b_hit <= 1'b1;
          res_q.b_idx <= cmp_idx_q;
        end
        if (top_match && !res_q.t_hit) begin
          res_q.t_hit <= 1'b1;
          res_q.t_idx <= cmp_idx_q;
        end
      end
    end
  end

endmodule

[rtl/interlaced_track_table_placer_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interlaced_track_table_placer_unit: table placement on interlaced tracks
// Searches the bottom and top slot memories for a table and either reports
// the overwrite it causes, places it in the next free slot or reports full.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one item: a table
// level and key. The output channel (out_valid_o / out_stall_i) returns one
// result item per input item: outcome, slot index, read-modify-write class,
// head sector and the saturating overwrite total.
// Each item is searched against both slot memories in parallel, one slot
// per cycle, over the memory read port. The next item is taken in the
// cycle after the result has moved into the output register, so a new
// item is not taken while one is still being searched or resolved.
// When the receiver stalls, the result holds in the output register; a
// following item is still searched, and waits before its update until the
// register is free. Reset empties every slot through the fill counts and
// clears the head sector and the total; no clearing pass is needed.
// ---------------------------------------------------------------------------
module interlaced_track_table_placer_unit
  import itp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [LEVEL_W-1:0]    table_level_i,
  input  logic [KEY_W-1:0]      table_key_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUTCOME_W-1:0]  outcome_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic [CLS_W-1:0]      rmw_class_o,
  output logic [SECT_W-1:0]     head_sector_o,
  output logic [TOTAL_W-1:0]    overwrite_total_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_e;

  localparam logic [SECT_W-1:0]  S_SECT    = SECT_W'(SECTORS_PER_SLOT);
  localparam logic [SECT_W-1:0]  S_M1      = SECT_W'(SECTORS_PER_SLOT - 1);
  localparam logic [SECT_W-1:0]  S2_M2     = SECT_W'(2 * SECTORS_PER_SLOT - 2);
  localparam logic [TOTAL_W-1:0] ADD_FULL  = TOTAL_W'(SECTORS_PER_SLOT);
  localparam logic [TOTAL_W-1:0] ADD_HALF  = TOTAL_W'(SECTORS_PER_SLOT / 2);
  localparam logic [CNT_W-1:0]   BOT_CAP   = CNT_W'(SLOT_COUNT);
  localparam logic [HCNT_W-1:0]  EVEN_LIM  = HCNT_W'(EVEN_CAP);
  localparam logic [HCNT_W-1:0]  ODD_LIM   = HCNT_W'(ODD_CAP);

  state_e               state_q;
  logic [LEVEL_W-1:0]   level_q;
  logic [KEY_W-1:0]     key_q;
  fill_t                fill_q;
  logic [SECT_W-1:0]    sector_q;
  logic [TOTAL_W-1:0]   total_q;
  logic                 out_valid_q;
  outcome_e             out_outcome_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [CLS_W-1:0]     out_cls_q;

  logic                 in_accept;
  logic                 out_free;
  logic                 resolve_fire;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 scan_done;
  scan_res_t            scan_res;
  logic [ENTRY_W-1:0]   bot_rdata;
  logic [ENTRY_W-1:0]   top_rdata;

  outcome_e             outcome_d;
  logic [IDX_W-1:0]     slot_d;
  logic [CLS_W-1:0]     cls_d;
  logic [SECT_W-1:0]    sector_d;
  logic [TOTAL_W-1:0]   total_d;
  fill_t                fill_d;
  logic                 bot_we;
  logic                 top_we;
  logic [IDX_W-1:0]     nb_idx;
  logic [TOTAL_W-1:0]   add_amt;
  logic [TOTAL_W:0]     total_sum;

  // Handshakes.
  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign resolve_fire = (state_q == ST_RESOLVE) && out_free;

  // Slot memories and search unit.
  itp_store u_bot_store (
    .clk_i   (clk_i),
    .we_i    (bot_we),
    .waddr_i (slot_d),
    .wdata_i ({level_q, key_q}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (bot_rdata)
  );

  itp_store u_top_store (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (slot_d),
    .wdata_i ({level_q, key_q}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (top_rdata)
  );

  itp_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .level_i     (level_q),
    .key_i       (key_q),
    .fill_i      (fill_q),
    .bot_rdata_i (bot_rdata),
    .top_rdata_i (top_rdata),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .done_o      (scan_done),
    .res_o       (scan_res)
  );

  // Bottom slot 0 borders top slots 0 and 1; any other slot i borders i and i-1.
  assign nb_idx = (scan_res.b_idx == '0) ? IDX_W'(1) : (scan_res.b_idx - IDX_W'(1));

  // Overwrite charge of a bottom hit, added with saturation.
  always_comb begin
    case (cls_d)
      2'd2:    add_amt = ADD_FULL;
      2'd1:    add_amt = ADD_HALF;
      default: add_amt = '0;
    endcase
  end
  assign total_sum = {1'b0, total_q} + {1'b0, add_amt};

  // Outcome decision and the updates it implies.
  always_comb begin
    outcome_d = OC_FULL;
    slot_d    = '0;
    cls_d     = '0;
    sector_d  = sector_q;
    fill_d    = fill_q;
    bot_we    = 1'b0;
    top_we    = 1'b0;
    if (scan_res.b_hit) begin
      outcome_d = OC_BOT_OVR;
      slot_d    = scan_res.b_idx;
      cls_d     = CLS_W'(top_valid(scan_res.b_idx, fill_q)) +
                  CLS_W'(top_valid(nb_idx, fill_q));
      sector_d  = SECT_W'(scan_res.b_idx) * S_SECT + S_M1;
    end else if (scan_res.t_hit) begin
      slot_d = scan_res.t_idx;
      if (!scan_res.t_idx[0]) begin
        outcome_d = OC_TOP_EVEN;
        sector_d  = SECT_W'(scan_res.t_idx) * S_SECT + S2_M2;
      end else begin
        outcome_d = OC_TOP_ODD;
        sector_d  = SECT_W'(scan_res.t_idx) * S_SECT + S_M1;
      end
    end else if (fill_q.bottom < BOT_CAP) begin
      outcome_d     = OC_NEW_BOT;
      slot_d        = fill_q.bottom[IDX_W-1:0];
      bot_we        = resolve_fire;
      sector_d      = sector_q + ((fill_q.bottom == '0) ? S_M1 : S_SECT);
      fill_d.bottom = fill_q.bottom + CNT_W'(1);
    end else if (fill_q.even < EVEN_LIM) begin
      outcome_d   = OC_NEW_EVEN;
      slot_d      = IDX_W'({fill_q.even, 1'b0});
      top_we      = resolve_fire;
      sector_d    = sector_q + S2_M2;
      fill_d.even = fill_q.even + HCNT_W'(1);
    end else if (fill_q.odd < ODD_LIM) begin
      outcome_d  = OC_NEW_ODD;
      slot_d     = IDX_W'({fill_q.odd, 1'b1});
      top_we     = resolve_fire;
      sector_d   = sector_q + S2_M2;
      fill_d.odd = fill_q.odd + HCNT_W'(1);
    end
  end

  assign total_d = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  // Sequencer, placement state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fill_q        <= '0;
      sector_q      <= '0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
      out_outcome_q <= OC_FULL;
      out_slot_q    <= '0;
      out_cls_q     <= '0;
      level_q       <= '0;
      key_q         <= '0;
    end else begin
      if (resolve_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            level_q <= table_level_i;
            key_q   <= table_key_i;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (out_free) begin
            fill_q        <= fill_d;
            sector_q      <= sector_d;
            total_q       <= total_d;
            out_outcome_q <= outcome_d;
            out_slot_q    <= SLOT_OUT_W'(slot_d);
            out_cls_q     <= cls_d;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result ports.
  assign out_valid_o       = out_valid_q;
  assign outcome_o         = out_outcome_q;
  assign slot_index_o      = out_slot_q;
  assign rmw_class_o       = out_cls_q;
  assign head_sector_o     = sector_q;
  assign overwrite_total_o = total_q;

  // The bottom fill count never passes the slot count.
  a_bottom_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q.bottom <= BOT_CAP)
    else $error("bottom fill count beyond slot count");

  // No slot memory is written while the search unit reads it.
  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bot_we || top_we) |-> !rd_en)
    else $error("slot write during search");

  // The overwrite total never goes down.
  a_total_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= $past(total_q))
    else $error("overwrite total decreased");

  // Only a bottom overwrite carries a nonzero read-modify-write class.
  a_cls_bottom_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (rmw_class_o != '0)) |-> (outcome_o == OC_BOT_OVR))
    else $error("rmw class on a non bottom outcome");

  // A full outcome leaves the head sector where it was.
  a_full_keeps_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resolve_fire && (outcome_d == OC_FULL)) |=> (sector_q == $past(sector_q)))
    else $error("head sector moved on a full outcome");

endmodule
